FILE: sv/bptc_pkg.sv
// shared types and constants for the barometric compensation pipeline
package bptc_pkg;
	localparam int unsigned FineOffset = 128000;
	localparam int unsigned PressBase  = 1048576;
	localparam int unsigned PressScale = 3125;
	localparam int unsigned TRound     = 128;
	localparam int unsigned TMul       = 5;

	localparam int unsigned DivSteps = 64;

	typedef enum logic [1:0] {
		REG_CALIB_TEMP    = 2'd0,
		REG_CALIB_PRESS_A = 2'd1,
		REG_CALIB_PRESS_B = 2'd2,
		REG_CALIB_PRESS_C = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [19:0] adc_temp;
		logic [19:0] adc_press;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic signed [31:0] fine_temperature;
		logic [31:0]        pressure;
		logic               zero_divisor;
	} out_item_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic signed [31:0] temperature;
		logic signed [31:0] fine_temperature;
		logic               zero_divisor;
		logic               neg;
	} div_tag_t;

	typedef struct packed {
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} press_cal_t;
endpackage

FILE: sv/bptc_stream_if.sv
// valid/ready channel carrying a payload
interface bptc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/bptc_front.sv
// front pipeline: temperature compensation and pressure numerator/divisor
module bptc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  bptc_pkg::in_item_t in_item,
	input  logic [47:0]        calib_temp,
	input  bptc_pkg::press_cal_t cal,
	output logic               out_valid,
	output logic signed [63:0] num,
	output logic signed [63:0] den,
	output bptc_pkg::div_tag_t tag
);
	import bptc_pkg::*;

	// stage 1: temperature products
	logic [3:0] v_q;
	logic signed [31:0] ta_s1, td_s1;
	logic [19:0] ap_s1;
	logic signed [31:0] t1x, t2x, t3x;
	logic [31:0] at;
	assign at  = {12'd0, in_item.adc_temp};
	assign t1x = {16'd0, calib_temp[15:0]};
	assign t2x = {{16{calib_temp[31]}}, calib_temp[31:16]};
	assign t3x = {{16{calib_temp[47]}}, calib_temp[47:32]};

	// stage 2
	logic signed [31:0] ta_s2, dd_s2;
	logic [19:0] ap_s2;
	// stage 3
	logic signed [31:0] ta_s3, db_s3;
	logic [19:0] ap_s3;
	// stage 4: fine, x (x always fits 33 signed bits)
	logic signed [31:0] fine_s4;
	logic signed [32:0] x_s4;
	logic [19:0] ap_s4;
	// stage 5: x products
	logic signed [31:0] fine_s5, temp_s5;
	logic signed [63:0] xx_s5, xp5_s5, xp2_s5, x_s5;
	logic [19:0] ap_s5;
	// stage 6
	logic signed [31:0] fine_s6, temp_s6;
	logic signed [63:0] y_s6, z_s6;
	logic [19:0] ap_s6;
	// stage 7
	logic signed [31:0] fine_s7, temp_s7;
	logic signed [63:0] z_s7, pn_s7;
	// stage 8
	logic signed [31:0] fine_s8, temp_s8;
	logic signed [63:0] zz_s8, num_s8;

	logic signed [31:0] a_w, b_w, tmp_w, f_w;
	logic signed [63:0] x_w, z5_w, p1x;
	assign a_w  = ta_s3;
	assign f_w  = ta_s3 + db_s3;
	assign tmp_w = $signed(fine_s4 * 32'(TMul) + 32'(TRound)) >>> 8;
	assign x_w  = 64'(f_w) - 64'(FineOffset);
	assign z5_w = ((xx_s5 * 64'(cal.p3)) >>> 8) + ((xp2_s5) <<< 12);
	assign p1x  = {48'd0, cal.p1};
	assign b_w  = db_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	logic [3:0] w_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (adv) begin
			w_q <= {w_q[2:0], v_q[3]};
		end
	end
	assign out_valid = w_q[3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1 <= ((at >> 3) - (t1x <<< 1)) * t2x;
			td_s1 <= (at >> 4) - t1x;
			ap_s1 <= in_item.adc_press;

			ta_s2 <= ta_s1 >>> 11;
			dd_s2 <= (td_s1 * td_s1) >>> 12;
			ap_s2 <= ap_s1;

			ta_s3 <= ta_s2;
			db_s3 <= (dd_s2 * t3x) >>> 14;
			ap_s3 <= ap_s2;

			fine_s4 <= a_w + b_w;
			x_s4    <= x_w[32:0];
			ap_s4   <= ap_s3;

			fine_s5 <= fine_s4;
			temp_s5 <= tmp_w;
			xx_s5   <= x_s4 * x_s4;
			xp5_s5  <= x_s4 * 64'(cal.p5);
			xp2_s5  <= x_s4 * 64'(cal.p2);
			x_s5    <= 64'(x_s4);
			ap_s5   <= ap_s4;

			fine_s6 <= fine_s5;
			temp_s6 <= temp_s5;
			y_s6 <= xx_s5 * 64'(cal.p6) + (xp5_s5 <<< 17) + (64'(cal.p4) <<< 35);
			z_s6 <= z5_w;
			ap_s6 <= ap_s5;

			fine_s7 <= fine_s6;
			temp_s7 <= temp_s6;
			z_s7  <= (64'sd1 <<< 47) + z_s6;
			pn_s7 <= ((64'(PressBase) - 64'(ap_s6)) <<< 31) - y_s6;

			fine_s8 <= fine_s7;
			temp_s8 <= temp_s7;
			zz_s8   <= (z_s7 * p1x) >>> 33;
			num_s8  <= pn_s7 * 64'(PressScale);
		end
	end

	assign num = num_s8;
	assign den = zz_s8;
	assign tag.temperature      = temp_s8;
	assign tag.fine_temperature = fine_s8;
	assign tag.zero_divisor     = (zz_s8 == 64'sd0);
	assign tag.neg              = num_s8[63] ^ zz_s8[63];
	logic unused;
	assign unused = ^x_s5;
endmodule

FILE: sv/bptc_div.sv
// pipelined restoring divider on unsigned magnitudes with sign fix, one quotient bit per stage
module bptc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	input  bptc_pkg::div_tag_t in_tag,
	output logic               out_valid,
	output logic signed [63:0] quot,
	output bptc_pkg::div_tag_t out_tag
);
	import bptc_pkg::*;

	logic [DivSteps:0]      v_q;
	logic [63:0]            n_q [DivSteps+1];
	logic [64:0]            r_q [DivSteps+1];
	logic [63:0]            d_q [DivSteps+1];
	div_tag_t               t_q [DivSteps+1];
	logic [64:0]            sh_w [DivSteps];
	logic [64:0]            df_w [DivSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[DivSteps-1:0], in_valid};
		end
	end

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		assign sh_w[i] = {r_q[i][63:0], n_q[i][63]};
		assign df_w[i] = sh_w[i] - {1'b0, d_q[i]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_q[0] <= num[63] ? 64'(-num) : num;
			d_q[0] <= den[63] ? 64'(-den) : den;
			r_q[0] <= '0;
			t_q[0] <= in_tag;
			for (int i = 0; i < DivSteps; i++) begin
				r_q[i+1] <= df_w[i][64] ? sh_w[i] : df_w[i];
				n_q[i+1] <= {n_q[i][62:0], ~df_w[i][64]};
				d_q[i+1] <= d_q[i];
				t_q[i+1] <= t_q[i];
			end
		end
	end

	assign out_valid = v_q[DivSteps];
	assign quot      = t_q[DivSteps].neg ? 64'(-n_q[DivSteps]) : n_q[DivSteps];
	assign out_tag   = t_q[DivSteps];
	logic unused;
	assign unused = ^r_q[DivSteps];
endmodule

FILE: sv/bptc_back.sv
// back pipeline: second-order pressure correction and output register
module bptc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [63:0] quot,
	input  bptc_pkg::div_tag_t tag,
	input  bptc_pkg::press_cal_t cal,
	output logic               out_valid,
	output bptc_pkg::out_item_t out_item
);
	import bptc_pkg::*;

	logic [3:0] v_q;
	div_tag_t t_s1, t_s2, t_s3, t_s4;
	logic signed [63:0] p_s1, h_s1, p_s2, v_s2, p_s3, u_s3, v_s3;
	logic [63:0] hl_s2;
	logic [31:0] hx_s2;
	logic signed [63:0] fin_s4;
	logic signed [63:0] h_w, hh_w, u_w, r_w;
	assign h_w = quot >>> 13;
	// h*h modulo 2^64 from 32-bit halves: lo*lo + (2*hi*lo << 32)
	assign hh_w = hl_s2 + {hx_s2[30:0], 33'd0};
	assign u_w = (64'(cal.p9) * hh_w) >>> 25;
	assign r_w = ((p_s3 + u_s3 + v_s3) >>> 8) + (64'(cal.p7) <<< 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= tag;
			p_s1 <= quot;
			h_s1 <= h_w;
			t_s2 <= t_s1;
			p_s2 <= p_s1;
			hl_s2 <= h_s1[31:0] * h_s1[31:0];
			hx_s2 <= h_s1[63:32] * h_s1[31:0];
			v_s2 <= (64'(cal.p8) * p_s1) >>> 19;
			t_s3 <= t_s2;
			p_s3 <= p_s2;
			u_s3 <= u_w;
			v_s3 <= v_s2;
			t_s4 <= t_s3;
			fin_s4 <= t_s3.zero_divisor ? 64'sd0 : r_w;
		end
	end

	assign out_valid = v_q[3];
	assign out_item.temperature      = t_s4.temperature;
	assign out_item.fine_temperature = t_s4.fine_temperature;
	assign out_item.pressure         = fin_s4[31:0];
	assign out_item.zero_divisor     = t_s4.zero_divisor;
endmodule

FILE: sv/baro_pressure_temp_compensation_unit.sv
// Fully pipelined integer temperature/pressure compensation. One item per
// cycle is accepted while the output buffer has room; the pipeline is 8 front
// stages, 65 divider stages, 4 back stages and a 2-entry output buffer. The
// long pole is the 64-bit signed division, built as one quotient bit per
// register stage. The whole pipeline advances only when the output buffer
// has room, so a stall freezes every stage and nothing is lost or repeated.
module baro_pressure_temp_compensation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	bptc_stream_if.sink   in_ch,
	bptc_stream_if.source out_ch
);
	import bptc_pkg::*;

	// calibration registers
	logic [47:0] calib_temp_q;
	logic [63:0] calib_press_a_q, calib_press_b_q;
	logic [15:0] calib_press_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_temp_q    <= '0;
			calib_press_a_q <= '0;
			calib_press_b_q <= '0;
			calib_press_c_q <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_CALIB_TEMP:    calib_temp_q    <= cfg_wdata[47:0];
				REG_CALIB_PRESS_A: calib_press_a_q <= cfg_wdata;
				REG_CALIB_PRESS_B: calib_press_b_q <= cfg_wdata;
				REG_CALIB_PRESS_C: calib_press_c_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	press_cal_t cal;
	assign cal.p1 = calib_press_a_q[15:0];
	assign cal.p2 = calib_press_a_q[31:16];
	assign cal.p3 = calib_press_a_q[47:32];
	assign cal.p4 = calib_press_a_q[63:48];
	assign cal.p5 = calib_press_b_q[15:0];
	assign cal.p6 = calib_press_b_q[31:16];
	assign cal.p7 = calib_press_b_q[47:32];
	assign cal.p8 = calib_press_b_q[63:48];
	assign cal.p9 = calib_press_c_q;

	// output buffer (2 entries) with pipeline advance only when it has room
	out_item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       adv, back_v, push, pop;
	out_item_t  back_item;

	// advance only when the item leaving the pipe has a free slot
	assign adv = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !back_v) || pop;
	assign in_ch.ready = adv;

	logic               f_v, d_v;
	logic signed [63:0] num, den, quot;
	div_tag_t           f_tag, d_tag;

	bptc_front u_front (
		.clk, .arst_n, .adv,
		.in_valid(in_ch.valid), .in_item(in_ch.payload),
		.calib_temp(calib_temp_q), .cal,
		.out_valid(f_v), .num, .den, .tag(f_tag)
	);

	bptc_div u_div (
		.clk, .arst_n, .adv,
		.in_valid(f_v), .num, .den, .in_tag(f_tag),
		.out_valid(d_v), .quot, .out_tag(d_tag)
	);

	bptc_back u_back (
		.clk, .arst_n, .adv,
		.in_valid(d_v), .quot, .tag(d_tag), .cal,
		.out_valid(back_v), .out_item(back_item)
	);

	assign push = adv && back_v;
	assign pop  = out_ch.valid && out_ch.ready;
	assign out_ch.valid   = (cnt_q != 2'd0);
	assign out_ch.payload = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (pop) rd_q <= ~rd_q;
		end
	end

	// new entry goes behind the ones already held
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[rd_q ^ cnt_q[0]] <= back_item;
		end
	end
endmodule

FILE: bench/baro_pressure_temp_compensation_unit_tb.sv
// testbench for the barometric temperature/pressure compensation unit
module baro_pressure_temp_compensation_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bptc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	bptc_stream_if #(.payload_t(in_item_t))  in_ch();
	bptc_stream_if #(.payload_t(out_item_t)) out_ch();

	baro_pressure_temp_compensation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// calibration words as the block should hold them
	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_press_c;

	in_item_t  reading_q[$];      // readings waiting to be offered
	out_item_t comp_expect_q[$];  // compensated results still owed by the block

	int  err_count;
	bit  in_xfer;                 // input transfer seen at the last rising edge
	int  burst_left, gap_left;
	bit  tx_dense;                // sender offers back to back when set
	int  rx_mode;
	int  rx_cycle;
	int  hold_left;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard limit on run time, far beyond the slowest correct run
	initial begin
		#4ms;
		$display("baro_pressure_temp_compensation_unit_tb NOT OK");
		$finish;
	end

	function automatic logic [63:0] sx16(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	// integer compensation, temperature path in 32 bits, pressure path in 64 bits
	function automatic out_item_t compensate(input in_item_t rd);
		logic [31:0] at, t1, t2, t3, a, d, b, fine, tmp;
		logic [63:0] x, y, z, p, num, an, ad, q, h, u, v;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		out_item_t   r;
		at = {12'd0, rd.adc_temp};
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		tmp = ((at >> 3) - (t1 << 1)) * t2;
		a = $signed(tmp) >>> 11;
		d = (at >> 4) - t1;
		tmp = d * d;
		tmp = $signed(tmp) >>> 12;
		tmp = tmp * t3;
		b = $signed(tmp) >>> 14;
		fine = a + b;
		tmp = fine * TMul + TRound;
		r.temperature = $signed(tmp) >>> 8;
		r.fine_temperature = fine;

		p1 = {48'd0, cal_press_a[15:0]};
		p2 = sx16(cal_press_a[31:16]);
		p3 = sx16(cal_press_a[47:32]);
		p4 = sx16(cal_press_a[63:48]);
		p5 = sx16(cal_press_b[15:0]);
		p6 = sx16(cal_press_b[31:16]);
		p7 = sx16(cal_press_b[47:32]);
		p8 = sx16(cal_press_b[63:48]);
		p9 = sx16(cal_press_c);

		x = {{32{fine[31]}}, fine} - 64'(FineOffset);
		y = x * x * p6;
		y = y + ((x * p5) << 17);
		y = y + (p4 << 35);
		z = $signed(x * x * p3) >>> 8;
		z = z + ((x * p2) << 12);
		z = $signed(((64'd1 << 47) + z) * p1) >>> 33;

		r.pressure = '0;
		r.zero_divisor = 1'b0;
		if (z == 64'd0) begin
			r.zero_divisor = 1'b1;
		end else begin
			p = 64'(PressBase) - {44'd0, rd.adc_press};
			num = ((p << 31) - y) * 64'(PressScale);
			// truncating signed divide, most negative / -1 wraps onto itself
			an = num[63] ? -num : num;
			ad = z[63] ? -z : z;
			q = an / ad;
			p = (num[63] ^ z[63]) ? -q : q;
			h = $signed(p) >>> 13;
			u = $signed(p9 * h * h) >>> 25;
			v = $signed(p8 * p) >>> 19;
			p = $signed(p + u + v) >>> 8;
			p = p + (p7 << 4);
			r.pressure = p[31:0];
		end
		return r;
	endfunction

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_xfer) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (reading_q.size() > 0) begin
					in_ch.payload <= reading_q.pop_front();
					in_ch.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = tx_dense ? 0 : $urandom_range(0, 6);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern depends on the phase, plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
				out_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: begin
						out_ch.ready <= 1'b1;
					end
					1: begin
						out_ch.ready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						out_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ch.ready <= ((rx_cycle % 7) < 4);
					end
				endcase
			end
		end
	end

	// monitor: predict on each input transfer, check on each output transfer
	always @(posedge clk) begin
		out_item_t want, got;
		in_xfer = arst_n && in_ch.valid && in_ch.ready;
		if (in_xfer)
			comp_expect_q.push_back(compensate(in_ch.payload));
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (comp_expect_q.size() == 0) begin
				err_count++;
				$display("%t unexpected result: expected none, actual %h", $time, got);
			end else begin
				want = comp_expect_q.pop_front();
				if (got.temperature !== want.temperature) begin
					err_count++;
					$display("%t temperature: expected %0d, actual %0d",
						$time, want.temperature, got.temperature);
				end
				if (got.fine_temperature !== want.fine_temperature) begin
					err_count++;
					$display("%t fine_temperature: expected %0d, actual %0d",
						$time, want.fine_temperature, got.fine_temperature);
				end
				if (got.pressure !== want.pressure) begin
					err_count++;
					$display("%t pressure: expected %h, actual %h",
						$time, want.pressure, got.pressure);
				end
				if (got.zero_divisor !== want.zero_divisor) begin
					err_count++;
					$display("%t zero_divisor: expected %b, actual %b",
						$time, want.zero_divisor, got.zero_divisor);
				end
			end
		end
	end

	// register write; the mirror keeps only the bits each register holds
	task automatic write_calib(input reg_index_t idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_CALIB_TEMP:    cal_temp = data[47:0];
			REG_CALIB_PRESS_A: cal_press_a = data;
			REG_CALIB_PRESS_B: cal_press_b = data;
			default:           cal_press_c = data[15:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_calib(input logic [63:0] t, input logic [63:0] pa,
			input logic [63:0] pb, input logic [63:0] pc);
		write_calib(REG_CALIB_TEMP, t);
		write_calib(REG_CALIB_PRESS_A, pa);
		write_calib(REG_CALIB_PRESS_B, pb);
		write_calib(REG_CALIB_PRESS_C, pc);
	endtask

	// wait until all readings have gone in and every result has come back
	task automatic drain();
		while (reading_q.size() > 0 || in_ch.valid || comp_expect_q.size() > 0)
			@(posedge clk);
		// every result is back, so the pipeline is already empty; idle before the next phase
		repeat (100) @(negedge clk);
	endtask

	task automatic add_reading(input logic [19:0] t, input logic [19:0] p);
		in_item_t rd;
		rd.adc_temp = t;
		rd.adc_press = p;
		reading_q.push_back(rd);
	endtask

	// mostly realistic readings, some anywhere in the 20-bit range
	task automatic add_random(input int n);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				add_reading(20'($urandom), 20'($urandom));
			else
				add_reading(20'($urandom_range(480000, 560000)),
					20'($urandom_range(250000, 450000)));
		end
	endtask

	// typical calibration words, with a little spread around each when jitter is set
	task automatic load_typical(input bit jitter);
		logic [15:0] w[12];
		int j;
		w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685,
			16'd3024, 16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
		if (jitter)
			for (j = 0; j < 12; j++)
				w[j] = w[j] + 16'($urandom_range(0, 64)) - 16'd32;
		load_calib({16'd0, w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
			{w[10], w[9], w[8], w[7]}, {48'd0, w[11]});
	endtask

	initial begin
		int ph;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CALIB_TEMP;
		cfg_wdata = '0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		err_count = 0;
		in_xfer = 1'b0;
		burst_left = 0;
		gap_left = 0;
		tx_dense = 1'b0;
		rx_mode = 0;
		rx_cycle = 0;
		hold_left = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers still at reset: p1 is zero, so every divisor is zero
		add_reading(20'd0, 20'd0);
		add_reading(20'hFFFFF, 20'hFFFFF);
		add_reading(20'd519888, 20'd415148);
		drain();

		// typical calibration with field extremes and the usual operating point
		load_typical(1'b0);
		add_reading(20'd0, 20'd0);
		add_reading(20'hFFFFF, 20'hFFFFF);
		add_reading(20'd0, 20'hFFFFF);
		add_reading(20'hFFFFF, 20'd0);
		add_reading(20'd519888, 20'd415148);
		add_reading(20'h55555, 20'hAAAAA);
		add_reading(20'hAAAAA, 20'h55555);
		drain();

		// all words at their positive extreme, upper garbage above the temperature and pressure C registers
		load_calib(64'hFFFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
			64'h7FFF_7FFF_7FFF_7FFF, 64'hFFFF_FFFF_FFFF_7FFF);
		add_reading(20'd0, 20'd0);
		add_reading(20'hFFFFF, 20'hFFFFF);
		add_reading(20'd519888, 20'd415148);
		drain();

		// signed words at their negative extreme, p1 and t1 at their largest
		load_calib(64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
			64'h8000_8000_8000_8000, 64'h0000_0000_0000_8000);
		add_reading(20'd0, 20'hFFFFF);
		add_reading(20'hFFFFF, 20'd0);
		add_reading(20'd519888, 20'd415148);
		drain();

		// every bit set everywhere
		load_calib('1, '1, '1, '1);
		add_reading(20'hFFFFF, 20'hFFFFF);
		add_reading(20'd1, 20'd1);
		drain();

		// random phases, calibration and stall style chosen by the phase
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: load_typical(1'b1);
				1: load_calib({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
				2: load_typical(1'b0);
				default: begin
					// p1 zero again: zero divisor in the middle of the run
					load_typical(1'b1);
					write_calib(REG_CALIB_PRESS_A, {cal_press_a[63:16], 16'd0});
				end
			endcase
			rx_mode = ph % 4;
			tx_dense = (ph == 2);
			if (ph == 2)
				hold_req = 1'b1;  // back up the whole pipeline while the sender keeps going
			add_random(110);
			drain();
		end

		if (err_count == 0)
			$display("baro_pressure_temp_compensation_unit_tb OK");
		else
			$display("baro_pressure_temp_compensation_unit_tb NOT OK");
		$finish;
	end
endmodule

FILE: sim.f
sv/bptc_pkg.sv
sv/bptc_stream_if.sv
sv/bptc_front.sv
sv/bptc_div.sv
sv/bptc_back.sv
sv/baro_pressure_temp_compensation_unit.sv
bench/baro_pressure_temp_compensation_unit_tb.sv
